>>> hw/rtl/md4_pkg.sv
// md4 hasher shared types, constants and step tables
package md4_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned BlkBytes = 64;
	localparam int unsigned StepCnt = 48;

	localparam logic [WordW-1:0] IvA = 32'h67452301;
	localparam logic [WordW-1:0] IvB = 32'hefcdab89;
	localparam logic [WordW-1:0] IvC = 32'h98badcfe;
	localparam logic [WordW-1:0] IvD = 32'h10325476;
	localparam logic [WordW-1:0] KR2 = 32'h5a827999;
	localparam logic [WordW-1:0] KR3 = 32'h6ed9eba1;

	// request kinds carried on s_tuser
	localparam logic REQ_APPEND = 1'b0;
	localparam logic REQ_FINISH = 1'b1;

	typedef logic [3:0][WordW-1:0] chain_t;

	// control from the sequencer to the compression core
	typedef struct packed {
		logic start;
		logic init;
	} core_ctl_t;

	// status from the compression core
	typedef struct packed {
		logic busy;
		logic done;
	} core_sts_t;

	// message word index used by a step
	function automatic logic [3:0] msg_index(input logic [5:0] step);
		logic [3:0] j;
		logic [3:0] k;
		j = step[3:0];
		case (step[5:4])
			2'd0: k = j;
			2'd1: k = {j[1:0], j[3:2]};
			default: k = {j[0], j[1], j[2], j[3]};
		endcase
		return k;
	endfunction

	// rotate amount of a step
	function automatic logic [4:0] rot_amount(input logic [5:0] step);
		logic [4:0] s;
		case ({step[5:4], step[1:0]})
			4'b00_00: s = 5'd3;
			4'b00_01: s = 5'd7;
			4'b00_10: s = 5'd11;
			4'b00_11: s = 5'd19;
			4'b01_00: s = 5'd3;
			4'b01_01: s = 5'd5;
			4'b01_10: s = 5'd9;
			4'b01_11: s = 5'd13;
			4'b10_00: s = 5'd3;
			4'b10_01: s = 5'd9;
			4'b10_10: s = 5'd11;
			4'b10_11: s = 5'd15;
			default: s = 5'd3;
		endcase
		return s;
	endfunction

endpackage

>>> hw/rtl/md4_buf.sv
// md4 block buffer: 16 x 32 memory, byte writes, one registered read port
module md4_buf (
	input  logic        clk,
	input  logic        we,
	input  logic [5:0]  waddr,
	input  logic [7:0]  wdata,
	input  logic [3:0]  raddr,
	output logic [31:0] rdata
);

	logic [31:0] mem [16];
	logic [31:0] rdata_q;

	// byte lane write, little-endian within the word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr[5:2]][{waddr[1:0], 3'b000} +: 8] <= wdata;
		end
	end

	// synchronous read
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/md4_core.sv
// md4 compression core: chaining words, working words and the 48-step round unit
module md4_core (
	input  logic                clk,
	input  logic                arst_n,
	input  md4_pkg::core_ctl_t  ctl,
	input  logic [31:0]         mword,
	output logic [3:0]          raddr,
	output md4_pkg::chain_t     chain,
	output md4_pkg::core_sts_t  sts
);

	typedef enum logic [1:0] {
		C_IDLE,
		C_FETCH,
		C_RUN,
		C_ADD
	} cstate_t;

	cstate_t         state_q;
	logic [5:0]      step_q;
	logic [5:0]      step_nxt;
	logic            done_q;
	md4_pkg::chain_t chain_q;
	md4_pkg::chain_t work_q;
	logic [31:0]     mix;
	logic [31:0]     sum;
	logic [63:0]     rot;
	logic [4:0]      sh;
	logic [31:0]     tnew;

	assign step_nxt = step_q + 6'd1;

	// read address runs one step ahead of the round unit
	always_comb begin
		if (state_q == C_RUN) begin
			raddr = md4_pkg::msg_index(step_nxt);
		end else begin
			raddr = md4_pkg::msg_index(step_q);
		end
	end

	// round function on b, c, d
	always_comb begin
		case (step_q[5:4])
			2'd0: mix = (work_q[1] & work_q[2]) | (~work_q[1] & work_q[3]);
			2'd1: mix = ((work_q[1] & work_q[2]) | (work_q[1] & work_q[3])
				| (work_q[2] & work_q[3])) + md4_pkg::KR2;
			default: mix = (work_q[1] ^ work_q[2] ^ work_q[3]) + md4_pkg::KR3;
		endcase
		sum = work_q[0] + mix + mword;
		sh = md4_pkg::rot_amount(step_q);
		rot = {sum, sum} << sh;
		tnew = rot[63:32];
	end

	// sequencer and state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
			chain_q <= {md4_pkg::IvD, md4_pkg::IvC, md4_pkg::IvB, md4_pkg::IvA};
			work_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (ctl.init) begin
						chain_q <= {md4_pkg::IvD, md4_pkg::IvC, md4_pkg::IvB,
							md4_pkg::IvA};
					end
					if (ctl.start) begin
						work_q  <= chain_q;
						step_q  <= '0;
						state_q <= C_FETCH;
					end
				end
				C_FETCH: begin
					state_q <= C_RUN;
				end
				C_RUN: begin
					// roles rotate: next target is the old d
					work_q[0] <= work_q[3];
					work_q[3] <= work_q[2];
					work_q[2] <= work_q[1];
					work_q[1] <= tnew;
					if (step_q == 6'(md4_pkg::StepCnt - 1)) begin
						step_q  <= '0;
						state_q <= C_ADD;
					end else begin
						step_q <= step_nxt;
					end
				end
				C_ADD: begin
					for (int i = 0; i < 4; i++) begin
						chain_q[i] <= chain_q[i] + work_q[i];
					end
					done_q  <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign chain    = chain_q;
	assign sts.busy = (state_q != C_IDLE);
	assign sts.done = done_q;

endmodule

>>> hw/rtl/md4_hash_engine.sv
// md4 hasher top level: stream ports, padding sequencer and digest output
//
// Input channel s_*: one transfer per item. s_tuser is the request kind
// (0 append the byte in s_tdata[7:0], 1 finish the message). Output
// channel m_*: a finish gives four transfers, chaining words a..d, with
// m_tlast on the fourth.
// The 64th byte of a block starts a compression (a read-ahead state, 48
// round steps, an add), with the round unit taking one step a cycle from
// the block memory read port; the input is held off for the compression
// and for the cycle in which its done pulse is seen.
// A finish writes padding one byte a cycle, held while each of the one or
// two compressions in between runs, then copies the digest into an output
// register and restarts at the initial chaining values.
// A stalled receiver holds the digest in place; appends of the next
// message go on meanwhile, and only the next digest waits for the register.
// Reset (arst_n low) loads the initial chaining values and clears the byte
// count; the block memory needs no clearing.
module md4_hash_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] digest_word, [33:32] word_index, rest zero
	output logic        m_tlast    // last_word
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COMP,
		ST_PAD,
		ST_PCOMP,
		ST_WOUT
	} state_t;

	state_t             state_q;
	logic [63:0]        cnt_q;
	logic [63:0]        len_q;
	logic               first_q;
	logic               lenph_q;
	logic               fin_q;
	logic               obusy_q;
	logic [1:0]         oidx_q;
	md4_pkg::chain_t    dig_q;

	logic               in_xfer;
	logic               out_xfer;
	logic               buf_we;
	logic [5:0]         pos;
	logic [7:0]         buf_wdata;
	logic [3:0]         buf_raddr;
	logic [31:0]        buf_rdata;
	md4_pkg::core_ctl_t core_ctl;
	md4_pkg::core_sts_t core_sts;
	md4_pkg::chain_t    chain;

	assign pos      = cnt_q[5:0];
	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;

	// buffer write: accepted bytes, then padding bytes
	always_comb begin
		buf_we    = 1'b0;
		buf_wdata = s_tdata;
		if (state_q == ST_IDLE) begin
			buf_we = in_xfer && (s_tuser == md4_pkg::REQ_APPEND);
		end else if (state_q == ST_PAD) begin
			buf_we = 1'b1;
			if (first_q) begin
				buf_wdata = 8'h80;
			end else if (lenph_q) begin
				buf_wdata = len_q[{pos[2:0], 3'b000} +: 8];
			end else begin
				buf_wdata = 8'h00;
			end
		end
	end

	// a write to the last byte of a block starts a compression
	assign core_ctl.start = buf_we && (pos == 6'(md4_pkg::BlkBytes - 1));
	assign core_ctl.init  = (state_q == ST_WOUT) && !obusy_q;

	md4_buf u_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (pos),
		.wdata (buf_wdata),
		.raddr (buf_raddr),
		.rdata (buf_rdata)
	);

	md4_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (core_ctl),
		.mword  (buf_rdata),
		.raddr  (buf_raddr),
		.chain  (chain),
		.sts    (core_sts)
	);

	// sequencer, byte count and digest output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			len_q   <= '0;
			first_q <= 1'b0;
			lenph_q <= 1'b0;
			fin_q   <= 1'b0;
			obusy_q <= 1'b0;
			oidx_q  <= '0;
			dig_q   <= '0;
		end else begin
			if (buf_we) begin
				cnt_q <= cnt_q + 64'd1;
			end
			if (out_xfer) begin
				oidx_q <= oidx_q + 2'd1;
				if (oidx_q == 2'd3) begin
					obusy_q <= 1'b0;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (s_tuser == md4_pkg::REQ_FINISH) begin
							len_q   <= {cnt_q[60:0], 3'b000};
							first_q <= 1'b1;
							lenph_q <= 1'b0;
							state_q <= ST_PAD;
						end else if (core_ctl.start) begin
							state_q <= ST_COMP;
						end
					end
				end
				ST_COMP: begin
					if (core_sts.done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_PAD: begin
					first_q <= 1'b0;
					if (!lenph_q) begin
						lenph_q <= (pos == 6'd55);
					end
					if (core_ctl.start) begin
						fin_q   <= lenph_q && !first_q;
						state_q <= ST_PCOMP;
					end
				end
				ST_PCOMP: begin
					if (core_sts.done) begin
						state_q <= fin_q ? ST_WOUT : ST_PAD;
					end
				end
				ST_WOUT: begin
					if (!obusy_q) begin
						dig_q   <= chain;
						obusy_q <= 1'b1;
						oidx_q  <= '0;
						cnt_q   <= '0;
						fin_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = obusy_q;
	assign m_tdata  = {6'd0, oidx_q, dig_q[oidx_q]};
	assign m_tlast  = (oidx_q == 2'd3);

	// input is never taken while a compression runs
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !core_sts.busy)
		else $error("input ready during compression");

	// the buffer is never written under a running compression
	a_no_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		buf_we |-> !core_sts.busy)
		else $error("buffer write during compression");

	// a compression only finishes while the sequencer waits for it
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		core_sts.done |-> (state_q == ST_COMP || state_q == ST_PCOMP))
		else $error("unexpected compression done");

	// the final digest word frees the output register
	a_last_free: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
		else $error("output still valid after last word");

endmodule
